@@ hw/rtl/nva_pkg.sv @@
// Shared types, widths and constants for the nearest-vector answer checker.
`default_nettype none
package nva_pkg;

  // Default sizes handed to the top-level parameters
  localparam int unsigned MAX_QUERIES_DEF = 1024;
  localparam int unsigned DB_CAPACITY_DEF = 131072;

  // Field and state widths
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned INDEX_W    = 18;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned DBSIZE_W   = 18;
  localparam int unsigned MEAN_W     = 20;
  localparam int unsigned PROD_W     = 2 * ELEM_W;
  localparam int unsigned SQSUM_W    = 40;
  localparam int unsigned ROOT_W     = SQSUM_W / 2;
  localparam int unsigned DSUM_W     = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Entries of the vector queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [COUNT_W-1:0]  EXPECTED_COUNT_RST = 11'd1;
  localparam logic [DBSIZE_W-1:0] DB_ENTRIES_RST     = 18'd100000;
  localparam logic [MEAN_W-1:0]   MAX_MEAN_RST       = 20'd393216;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_COUNT = 2'd0,
    CFG_DB_ENTRIES     = 2'd1,
    CFG_MAX_MEAN       = 2'd2
  } cfg_reg_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_COUNT = 2'd1,
    ST_INDEX = 2'd2,
    ST_MEAN  = 2'd3
  } status_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_ROOT,
    B_SUM,
    B_MUL,
    B_CMP
  } back_state_t;

  // One finished vector handed from front to back
  typedef struct packed {
    logic [SQSUM_W-1:0] square_sum;
    logic               fault;
    logic               set_end;
  } vec_entry_t;

  // Queue fill flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/nva_front.sv @@
// Front end: accepts element pairs, checks indexes, squares and accumulates per vector.
`default_nettype none
module nva_front #(
  parameter int unsigned DB_CAPACITY = nva_pkg::DB_CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [nva_pkg::ELEM_W-1:0]    query_element,
  input  wire logic [nva_pkg::ELEM_W-1:0]    base_element,
  input  wire logic [nva_pkg::INDEX_W-1:0]   chosen_index,
  input  wire logic                          vector_end,
  input  wire logic                          set_end,
  input  wire logic [nva_pkg::DBSIZE_W-1:0]  db_entries,
  input  wire nva_pkg::q_stat_t              q_stat,
  output logic                               push,
  output nva_pkg::vec_entry_t                push_entry
);
  import nva_pkg::*;

  localparam int unsigned LIM_W = DBSIZE_W + 1;
  localparam logic [LIM_W-1:0] CAP = LIM_W'(DB_CAPACITY);

  logic                 s1_valid_r, s1_end_r, s1_send_r, s1_fault_r;
  logic [ELEM_W-1:0]    s1_diff_r;
  logic                 s2_valid_r, s2_end_r, s2_send_r, s2_fault_r;
  logic [PROD_W-1:0]    s2_prod_r;
  logic [SQSUM_W-1:0]   acc_r, acc_nxt;
  logic                 vfault_r, vfault_nxt;

  logic                 advance;
  logic [LIM_W-1:0]     limit;
  logic                 idx_fault;
  logic [ELEM_W-1:0]    diff;
  logic [SQSUM_W:0]     sum_wide;
  logic [SQSUM_W-1:0]   sum_sat;

  // Stall the whole front only when a finished vector cannot enter the queue
  assign advance  = !(s2_valid_r && s2_end_r && q_stat.full);
  assign in_ready = advance;

  // Index limit is the smaller of the register and the capacity
  assign limit     = ({1'b0, db_entries} < CAP) ? {1'b0, db_entries} : CAP;
  assign idx_fault = ({1'b0, chosen_index} >= limit);
  assign diff      = (query_element >= base_element) ? (query_element - base_element)
                                                     : (base_element - query_element);

  // Saturating accumulate of the squared difference
  assign sum_wide = {1'b0, acc_r} + (SQSUM_W + 1)'(s2_prod_r);
  assign sum_sat  = sum_wide[SQSUM_W] ? {SQSUM_W{1'b1}} : sum_wide[SQSUM_W-1:0];

  assign push                  = s2_valid_r && s2_end_r && !q_stat.full;
  assign push_entry.square_sum = sum_sat;
  assign push_entry.fault      = vfault_r | s2_fault_r;
  assign push_entry.set_end    = s2_send_r;

  // Restart the vector sums after a finished vector
  always_comb begin
    acc_nxt    = acc_r;
    vfault_nxt = vfault_r;
    if (advance && s2_valid_r) begin
      acc_nxt    = s2_end_r ? '0 : sum_sat;
      vfault_nxt = s2_end_r ? 1'b0 : (vfault_r | s2_fault_r);
    end
  end

  // Control: stage valids and vector sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      acc_r      <= '0;
      vfault_r   <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      vfault_r <= vfault_nxt;
      if (advance) begin
        s1_valid_r <= in_valid;
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload: difference stage then square stage
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_diff_r  <= diff;
      s1_end_r   <= vector_end | set_end;
      s1_send_r  <= set_end;
      s1_fault_r <= idx_fault;
      s2_prod_r  <= s1_diff_r * s1_diff_r;
      s2_end_r   <= s1_end_r;
      s2_send_r  <= s1_send_r;
      s2_fault_r <= s1_fault_r;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nva_queue.sv @@
// Short queue of finished vectors between front and back.
`default_nettype none
module nva_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire nva_pkg::vec_entry_t  push_entry,
  input  wire logic                 pop,
  output nva_pkg::vec_entry_t       head,
  output nva_pkg::q_stat_t          q_stat
);
  import nva_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  vec_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

@@ hw/rtl/nva_back.sv @@
// Back end: bit-serial square root, distance sum, query count and status decision.
`default_nettype none
module nva_back #(
  parameter int unsigned MAX_QUERIES = nva_pkg::MAX_QUERIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire nva_pkg::vec_entry_t          head,
  input  wire nva_pkg::q_stat_t             q_stat,
  output logic                              pop,
  input  wire logic [nva_pkg::COUNT_W-1:0]  expected_count,
  input  wire logic [nva_pkg::MEAN_W-1:0]   max_mean_distance,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output nva_pkg::status_t                  status
);
  import nva_pkg::*;

  localparam int unsigned QW     = $clog2(MAX_QUERIES + 2);
  localparam int unsigned STEP_W = $clog2(ROOT_W);
  localparam int unsigned REM_W  = ROOT_W + 2;

  back_state_t          state_r, state_nxt;
  logic [SQSUM_W-1:0]   rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [STEP_W-1:0]    step_r;
  logic                 set_end_r, fault_r;
  logic [DSUM_W-1:0]    dsum_r;
  logic [QW-1:0]        qseen_r;
  logic [DSUM_W-1:0]    bound_r;
  logic                 out_valid_r;
  status_t              out_status_r;

  logic                 root_step, acc_step, mul_step, emit, last_step;
  logic [REM_W+1:0]     rem_sh, trial;
  logic                 ge;
  logic [DSUM_W:0]      dsum_wide;
  status_t              status_nxt;

  assign last_step = (step_r == STEP_W'(ROOT_W - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_stat.empty) state_nxt = B_ROOT;
      B_ROOT:  if (last_step) state_nxt = B_SUM;
      B_SUM:   state_nxt = set_end_r ? B_MUL : B_IDLE;
      B_MUL:   state_nxt = B_CMP;
      B_CMP:   if (!out_valid_r || out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop       = 1'b0;
    root_step = 1'b0;
    acc_step  = 1'b0;
    mul_step  = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      B_IDLE:  pop       = !q_stat.empty;
      B_ROOT:  root_step = 1'b1;
      B_SUM:   acc_step  = 1'b1;
      B_MUL:   mul_step  = 1'b1;
      B_CMP:   emit      = !out_valid_r || out_ready;
      default: pop       = 1'b0;
    endcase
  end

  // One root bit per cycle: bring down two radicand bits, try subtracting
  assign rem_sh = {rem_r, rad_r[SQSUM_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  // Saturating distance sum
  assign dsum_wide = {1'b0, dsum_r} + (DSUM_W + 1)'(root_r);

  // Status priority: count, then index, then mean
  always_comb begin
    if (32'(qseen_r) != 32'(expected_count)) status_nxt = ST_COUNT;
    else if (fault_r)                        status_nxt = ST_INDEX;
    else if (dsum_r > bound_r)               status_nxt = ST_MEAN;
    else                                     status_nxt = ST_VALID;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      dsum_r      <= '0;
      qseen_r     <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        step_r  <= '0;
        fault_r <= fault_r | head.fault;
      end else if (root_step) begin
        step_r <= step_r + 1'b1;
      end
      if (acc_step) begin
        dsum_r <= dsum_wide[DSUM_W] ? {DSUM_W{1'b1}} : dsum_wide[DSUM_W-1:0];
        if (qseen_r < QW'(MAX_QUERIES + 1)) qseen_r <= qseen_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        dsum_r      <= '0;
        qseen_r     <= '0;
        fault_r     <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      rad_r     <= head.square_sum;
      rem_r     <= '0;
      root_r    <= '0;
      set_end_r <= head.set_end;
    end else if (root_step) begin
      rad_r  <= {rad_r[SQSUM_W-3:0], 2'b00};
      rem_r  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
    // Limit times count fits in the distance-sum width
    if (mul_step) bound_r <= DSUM_W'(max_mean_distance) * DSUM_W'(expected_count);
    if (emit)     out_status_r <= status_nxt;
  end

  assign out_valid = out_valid_r;
  assign status    = out_status_r;

endmodule
`default_nettype wire

@@ hw/rtl/nearest_vector_answer_checker.sv @@
// With the back end idle, a set-end transaction reaches out_tvalid through the front stages,
//   queue write, pop, bit-serial root, sum, bound and status register, in that order.
// One element pair per cycle while the queue has room; each vector holds the shared root unit
//   for pop, root and sum, and bound and status on a set end, so short vectors throttle input.
// The status sits in an output register, so the back end moves on while it waits to be taken.
// Reset (synchronous, rst_n low): sums, counts, queue and handshakes clear; the registers
//   return to expected_count 1, database size 100000, max_mean_distance 393216.
`default_nettype none
module nearest_vector_answer_checker #(
  parameter int unsigned MAX_QUERIES = nva_pkg::MAX_QUERIES_DEF,
  parameter int unsigned DB_CAPACITY = nva_pkg::DB_CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // query_element [15:0], base_element [31:16], chosen_index [49:32], zero fill
  input  wire logic [55:0]                     in_tdata,
  // vector_end
  input  wire logic                            in_tuser,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status [1:0], zero fill
  output logic [7:0]                           out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [nva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nva_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nva_pkg::*;

  logic [COUNT_W-1:0]  expected_count_r;
  logic [DBSIZE_W-1:0] db_entries_r;
  logic [MEAN_W-1:0]   max_mean_r;

  logic                push, pop;
  vec_entry_t          push_entry, head;
  q_stat_t             q_stat;
  status_t             status;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_count_r <= EXPECTED_COUNT_RST;
      db_entries_r     <= DB_ENTRIES_RST;
      max_mean_r       <= MAX_MEAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_EXPECTED_COUNT: expected_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_DB_ENTRIES:     db_entries_r     <= cfg_wdata[DBSIZE_W-1:0];
        CFG_MAX_MEAN:       max_mean_r       <= cfg_wdata[MEAN_W-1:0];
        default:            max_mean_r       <= max_mean_r;
      endcase
    end
  end

  nva_front #(
    .DB_CAPACITY (DB_CAPACITY)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .query_element (in_tdata[15:0]),
    .base_element  (in_tdata[31:16]),
    .chosen_index  (in_tdata[49:32]),
    .vector_end    (in_tuser),
    .set_end       (in_tlast),
    .db_entries    (db_entries_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  nva_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  nva_back #(
    .MAX_QUERIES (MAX_QUERIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .expected_count    (expected_count_r),
    .max_mean_distance (max_mean_r),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .status            (status)
  );

  assign out_tdata = {6'b000000, status};

  // Queue never takes an entry while full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("vector pushed into full queue");

  // Queue never gives an entry while empty
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("vector popped from empty queue");

  // Front only stalls on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full)
    else $error("input stalled without a full queue");

endmodule
`default_nettype wire
